### rtl/cfp_pkg.sv
// ----------------------------------------------------------------------------
// cfp_pkg
// Shared codes and types for the checksummed frame parser.
// ----------------------------------------------------------------------------
package cfp_pkg;

    localparam logic [7:0] START_BYTE = 8'h3E;

    localparam int PHASE_W = 3;

    localparam logic [PHASE_W-1:0] PH_HUNT = 3'd0;
    localparam logic [PHASE_W-1:0] PH_CMD  = 3'd1;
    localparam logic [PHASE_W-1:0] PH_LEN  = 3'd2;
    localparam logic [PHASE_W-1:0] PH_HCHK = 3'd3;
    localparam logic [PHASE_W-1:0] PH_BODY = 3'd4;
    localparam logic [PHASE_W-1:0] PH_DCHK = 3'd5;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_HDR_ERR  = 2'd1;
    localparam logic [1:0] ST_BODY_ERR = 2'd2;

    typedef struct packed {
        logic       frame_end;
        logic [7:0] payload_byte;
        logic [7:0] payload_index;
        logic [7:0] command_code;
        logic [7:0] payload_length;
        logic [1:0] frame_status;
    } cfp_result_t;

endpackage

### rtl/cfp_parser_core.sv
// ----------------------------------------------------------------------------
// cfp_parser_core
// Frame parse state and per-byte step logic: header capture, checksum
// checks and payload pass-through.
// ----------------------------------------------------------------------------
module cfp_parser_core
    import cfp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        step_en,
    input  logic [7:0]  rx_byte,
    output logic        res_valid,
    output cfp_result_t res
);

    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [7:0]         held_command_reg, held_command_next;
    logic [7:0]         held_length_reg, held_length_next;
    logic [7:0]         body_count_reg, body_count_next;
    logic [7:0]         running_sum_reg, running_sum_next;
    logic [7:0]         hdr_sum;
    logic [7:0]         count_inc;

    assign hdr_sum   = held_command_reg + held_length_reg;
    assign count_inc = body_count_reg + 8'd1;

    always_comb begin
        phase_next        = phase_reg;
        held_command_next = held_command_reg;
        held_length_next  = held_length_reg;
        body_count_next   = body_count_reg;
        running_sum_next  = running_sum_reg;
        res_valid         = 1'b0;
        res.frame_end      = 1'b0;
        res.payload_byte   = 8'd0;
        res.payload_index  = 8'd0;
        res.command_code   = held_command_reg;
        res.payload_length = held_length_reg;
        res.frame_status   = ST_OK;
        case (phase_reg)
            PH_CMD: begin
                held_command_next = rx_byte;
                phase_next        = PH_LEN;
            end
            PH_LEN: begin
                held_length_next = rx_byte;
                phase_next       = PH_HCHK;
            end
            PH_HCHK: begin
                if (rx_byte != hdr_sum) begin
                    res_valid        = 1'b1;
                    res.frame_end    = 1'b1;
                    res.frame_status = ST_HDR_ERR;
                    phase_next       = PH_HUNT;
                end else begin
                    body_count_next  = 8'd0;
                    running_sum_next = 8'd0;
                    phase_next = (held_length_reg == 8'd0) ? PH_DCHK : PH_BODY;
                end
            end
            PH_BODY: begin
                res_valid         = 1'b1;
                res.payload_byte  = rx_byte;
                res.payload_index = body_count_reg;
                running_sum_next  = running_sum_reg + rx_byte;
                body_count_next   = count_inc;
                if (count_inc == held_length_reg) begin
                    phase_next = PH_DCHK;
                end
            end
            PH_DCHK: begin
                res_valid        = 1'b1;
                res.frame_end    = 1'b1;
                res.frame_status = (rx_byte == running_sum_reg) ? ST_OK : ST_BODY_ERR;
                phase_next       = PH_HUNT;
            end
            default: begin
                phase_next = (rx_byte == START_BYTE) ? PH_CMD : PH_HUNT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_HUNT;
            held_command_reg <= 8'd0;
            held_length_reg  <= 8'd0;
            body_count_reg   <= 8'd0;
            running_sum_reg  <= 8'd0;
        end else if (step_en) begin
            phase_reg        <= phase_next;
            held_command_reg <= held_command_next;
            held_length_reg  <= held_length_next;
            body_count_reg   <= body_count_next;
            running_sum_reg  <= running_sum_next;
        end
    end

    a_body_len_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_BODY) |-> (held_length_reg != 8'd0))
        else $error("payload phase with zero length");

    a_body_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_BODY) |-> (body_count_reg < held_length_reg))
        else $error("payload index past frame length");

    a_body_to_dchk: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_en && phase_reg == PH_BODY && count_inc == held_length_reg)
        |=> (phase_reg == PH_DCHK))
        else $error("last payload byte did not move to body checksum");

endmodule

### rtl/checksummed_frame_parser.sv
// ----------------------------------------------------------------------------
// checksummed_frame_parser
// Streaming parser for '>' cmd len hchk payload[len] bchk frames with
// 8-bit additive checksums.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_valid/s_ready/s_rx_byte carries one received byte per
//   transaction. Output channel m_valid/m_ready/m_* carries zero or one
//   result per input byte: a payload byte with its index (m_frame_end = 0)
//   or a status transaction ending the frame (m_frame_end = 1, status
//   ok / header error / body error).
//   Path: an accepted byte is held in the input register, then the parse
//   step registers its result into the result register.
//   Throughput: one byte per cycle while the receiver does not stall; the
//   parse step is combinational between the input and result registers.
//   Reset (aresetn low, synchronous) empties both registers and returns
//   the parser to hunting for the start byte.
//   When the receiver stalls, the pending result holds in the result
//   register and one further byte waits in the input register; s_ready
//   drops only while both are occupied.
// ----------------------------------------------------------------------------
module checksummed_frame_parser
    import cfp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_frame_end,
    output logic [7:0]  m_payload_byte,
    output logic [7:0]  m_payload_index,
    output logic [7:0]  m_command_code,
    output logic [7:0]  m_payload_length,
    output logic [1:0]  m_frame_status
);

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        out_valid_reg;
    cfp_result_t out_reg;
    logic        advance;
    logic        res_valid;
    cfp_result_t res;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    cfp_parser_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_en   (advance),
        .rx_byte   (in_byte_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_rx_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && res_valid) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_frame_end      = out_reg.frame_end;
    assign m_payload_byte   = out_reg.payload_byte;
    assign m_payload_index  = out_reg.payload_index;
    assign m_command_code   = out_reg.command_code;
    assign m_payload_length = out_reg.payload_length;
    assign m_frame_status   = out_reg.frame_status;

    a_result_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && res_valid) |=> out_valid_reg)
        else $error("produced result not registered");

    a_empty_accepts: assert property (@(posedge aclk) disable iff (!aresetn)
        (!in_valid_reg) |-> s_ready)
        else $error("input register empty but not ready");

    a_payload_status_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !out_reg.frame_end) |-> (out_reg.frame_status == ST_OK))
        else $error("payload transaction with nonzero status");

endmodule

### tb/tb_checksummed_frame_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_checksummed_frame_parser
// Self-checking testbench for the checksummed frame parser. Bytes go in on
// a valid/ready stream with random gaps while the result side stalls at
// random. A behavioral parser tracks every accepted byte, queues the
// payload and status transactions it expects, and each result is compared
// field by field in arrival order. Directed frames come first, then random
// frames with corrupted headers and bodies mixed with noise.
// ----------------------------------------------------------------------------
module tb_checksummed_frame_parser;
    import cfp_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 10;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_rx_byte;
    logic        m_valid;
    logic        m_ready;
    logic        m_frame_end;
    logic [7:0]  m_payload_byte;
    logic [7:0]  m_payload_index;
    logic [7:0]  m_command_code;
    logic [7:0]  m_payload_length;
    logic [1:0]  m_frame_status;

    checksummed_frame_parser dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_rx_byte        (s_rx_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_frame_end      (m_frame_end),
        .m_payload_byte   (m_payload_byte),
        .m_payload_index  (m_payload_index),
        .m_command_code   (m_command_code),
        .m_payload_length (m_payload_length),
        .m_frame_status   (m_frame_status)
    );

    initial aclk = 1'b0;
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // parser tracking state
    logic [PHASE_W-1:0] rx_phase = PH_HUNT;
    logic [7:0]         hdr_cmd = 8'h00;
    logic [7:0]         hdr_len = 8'h00;
    logic [7:0]         body_idx = 8'h00;
    logic [7:0]         body_sum = 8'h00;
    cfp_result_t        parsed_items[$];

    int  mismatches = 0;
    int  idle_cycles = 0;
    bit  src_idle = 1'b1;
    bit  snk_idle = 1'b1;

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want) begin
            report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
        end
    endtask

    task automatic track_frame(input logic [7:0] b);
        cfp_result_t r;
        logic [7:0]  hdr_sum;
        r = '0;
        r.command_code = hdr_cmd;
        r.payload_length = hdr_len;
        hdr_sum = hdr_cmd + hdr_len;
        case (rx_phase)
            PH_CMD: begin
                hdr_cmd = b;
                rx_phase = PH_LEN;
            end
            PH_LEN: begin
                hdr_len = b;
                rx_phase = PH_HCHK;
            end
            PH_HCHK: begin
                if (b != hdr_sum) begin
                    r.frame_end = 1'b1;
                    r.frame_status = ST_HDR_ERR;
                    parsed_items.push_back(r);
                    rx_phase = PH_HUNT;
                end else begin
                    body_idx = 8'h00;
                    body_sum = 8'h00;
                    rx_phase = (hdr_len == 8'h00) ? PH_DCHK : PH_BODY;
                end
            end
            PH_BODY: begin
                r.payload_byte = b;
                r.payload_index = body_idx;
                r.frame_status = ST_OK;
                parsed_items.push_back(r);
                body_sum = body_sum + b;
                body_idx = body_idx + 8'h01;
                if (body_idx == hdr_len) begin
                    rx_phase = PH_DCHK;
                end
            end
            PH_DCHK: begin
                r.frame_end = 1'b1;
                r.frame_status = (b == body_sum) ? ST_OK : ST_BODY_ERR;
                parsed_items.push_back(r);
                rx_phase = PH_HUNT;
            end
            default: begin
                rx_phase = (b == START_BYTE) ? PH_CMD : PH_HUNT;
            end
        endcase
    endtask

    always @(posedge aclk) begin
        cfp_result_t got;
        cfp_result_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                track_frame(s_rx_byte);
            end
            if (m_valid && m_ready) begin
                got = {m_frame_end, m_payload_byte, m_payload_index,
                       m_command_code, m_payload_length, m_frame_status};
                if (parsed_items.size() == 0) begin
                    report_mismatch($sformatf("result %h with nothing expected", got));
                end else begin
                    want = parsed_items.pop_front();
                    check_field("frame_end", got.frame_end, want.frame_end);
                    check_field("payload_byte", got.payload_byte, want.payload_byte);
                    check_field("payload_index", got.payload_index, want.payload_index);
                    check_field("command_code", got.command_code, want.command_code);
                    check_field("payload_length", got.payload_length, want.payload_length);
                    check_field("frame_status", got.frame_status, want.frame_status);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // result side: random stall before each transaction while snk_idle is set
    initial begin
        int unsigned stall;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            stall = snk_idle ? $urandom_range(0, 8) : 0;
            repeat (stall) begin
                @(negedge aclk);
                m_ready <= 1'b0;
            end
            @(negedge aclk);
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        gap = src_idle ? $urandom_range(0, 8) : 0;
        repeat (gap) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_rx_byte <= b;
        do @(posedge aclk); while (s_ready !== 1'b1);
    endtask

    task automatic test_noise_ignored();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(START_BYTE - 8'h01);
        send_byte(START_BYTE + 8'h01);
    endtask

    task automatic test_empty_frame();
        send_byte(START_BYTE);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h00);
    endtask

    // start byte as command, then a bad header sum
    task automatic test_header_mismatch();
        send_byte(START_BYTE);
        send_byte(START_BYTE);
        send_byte(8'h34);
        send_byte(8'h00);
    endtask

    task automatic test_payload_frames();
        send_byte(START_BYTE);
        send_byte(8'hFF);
        send_byte(8'h02);
        send_byte(8'h01);
        send_byte(8'hFF);
        send_byte(START_BYTE);
        send_byte(8'h3D);
        send_byte(START_BYTE);
        send_byte(8'h00);
        send_byte(8'h01);
        send_byte(8'h01);
        send_byte(8'h80);
        send_byte(8'h00);
    endtask

    task automatic test_random_frames();
        int unsigned frame_bytes;
        int unsigned kind;
        int unsigned n_noise;
        bit          long_done;
        logic [7:0]  cmd;
        logic [7:0]  len;
        logic [7:0]  hsum;
        logic [7:0]  bsum;
        logic [7:0]  pb;
        frame_bytes = 0;
        long_done = 1'b0;
        while (frame_bytes < 524) begin
            src_idle = ($urandom_range(0, 3) != 0);
            snk_idle = ($urandom_range(0, 3) != 0);
            n_noise = $urandom_range(0, 2);
            repeat (n_noise) begin
                pb = 8'($urandom_range(0, 255));
                if (pb == START_BYTE) begin
                    pb = 8'h00;
                end
                send_byte(pb);
            end
            frame_bytes += n_noise;
            kind = $urandom_range(0, 19);
            if (kind == 5) begin
                // raw byte stream, may open or break frames
                repeat (8) send_byte(8'($urandom_range(0, 255)));
                frame_bytes += 8;
            end else begin
                cmd = 8'($urandom_range(0, 255));
                if (!long_done && frame_bytes > 200) begin
                    len = 8'hFF;
                    long_done = 1'b1;
                end else if ($urandom_range(0, 3) == 0) begin
                    len = 8'($urandom_range(0, 40));
                end else begin
                    len = 8'($urandom_range(0, 6));
                end
                hsum = cmd + len;
                if (kind < 2) begin
                    hsum = hsum ^ (8'h01 << $urandom_range(0, 7));
                end
                send_byte(START_BYTE);
                send_byte(cmd);
                send_byte(len);
                send_byte(hsum);
                frame_bytes += 4;
                if (kind >= 2) begin
                    bsum = 8'h00;
                    repeat (len) begin
                        pb = 8'($urandom_range(0, 255));
                        bsum = bsum + pb;
                        send_byte(pb);
                    end
                    if (kind <= 4) begin
                        bsum = bsum ^ (8'h01 << $urandom_range(0, 7));
                    end
                    send_byte(bsum);
                    frame_bytes += len + 1;
                end
            end
        end
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_rx_byte = 8'h00;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_noise_ignored();
        test_empty_frame();
        test_header_mismatch();
        test_payload_frames();
        test_random_frames();

        @(negedge aclk);
        s_valid <= 1'b0;
        while (parsed_items.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
